>>> rtl/assert_macros.svh
// Assertion macros used by the checker file of the literal pool table.
// Depends on nothing; every macro samples on a rising clock edge and is
// disabled while the active-low reset is asserted.

`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LPDT_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LPDT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/lpdt_pkg.sv
// Package for the literal pool table: sizes, request codes and the structs
// passed between the top level and the row of entry cells. No dependencies.
`timescale 1ns / 1ps

package lpdt_pkg;

    // Table geometry.
    localparam int TABLE_DEPTH = 64;
    localparam int SYMBOL_BITS = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;

    // Request codes.
    localparam logic [2:0] MODE_CONST  = 3'd0;
    localparam logic [2:0] MODE_ADDR   = 3'd1;
    localparam logic [2:0] MODE_EXTERN = 3'd2;
    localparam logic [2:0] MODE_SINGLE = 3'd3;
    localparam logic [2:0] MODE_DOUBLE = 3'd4;
    localparam logic [2:0] MODE_START  = 3'd5;
    localparam logic [2:0] MODE_CLOSE  = 3'd6;

    // Assembler pass codes.
    localparam logic [1:0] PASS_ONE = 2'd1;
    localparam logic [1:0] PASS_TWO = 2'd2;

    // Reach limits and address steps.
    localparam logic [31:0] RANGE_INT   = 32'h0000_1000;
    localparam logic [31:0] RANGE_FP    = 32'h0000_0400;
    localparam logic [31:0] STEP_WORD   = 32'd4;
    localparam logic [31:0] STEP_DOUBLE = 32'd8;
    localparam logic [31:0] PC_AHEAD    = 32'd8;

    // Control sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_FINISH
    } state_t;

    // Literal being searched for or stored, broadcast to every cell.
    typedef struct packed {
        logic [2:0]             kind;
        logic [31:0]            first_word;
        logic [31:0]            second_word;
        logic [SYMBOL_BITS-1:0] symbol;
        logic [31:0]            pc_ahead;
        logic                   is_float;
    } query_t;

    // Search result handed from one cell to the next.
    typedef struct packed {
        logic        hit;
        logic [31:0] address;
    } link_t;

    // Write and placement controls shared by all cells.
    typedef struct packed {
        logic        wr_placed;
        logic [31:0] wr_address;
        logic        place_en;
        logic [31:0] place_base;
    } cell_ctl_t;

endpackage

>>> rtl/lpdt_if.sv
// Valid/ready channel interfaces for the literal pool table: request,
// response and pass configuration. Depends on lpdt_pkg for the symbol width.
`timescale 1ns / 1ps

interface lpdt_req_if;
    logic                            valid;
    logic                            ready;
    logic [2:0]                      mode;
    logic                            known_status;
    logic [31:0]                     value_low;
    logic [31:0]                     value_high;
    logic [lpdt_pkg::SYMBOL_BITS-1:0] symbol_id;
    logic [31:0]                     program_counter;
    logic [31:0]                     pool_start_address;

    modport source (
        output valid, mode, known_status, value_low, value_high, symbol_id,
               program_counter, pool_start_address,
        input  ready
    );
    modport sink (
        input  valid, mode, known_status, value_low, value_high, symbol_id,
               program_counter, pool_start_address,
        output ready
    );
endinterface

interface lpdt_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] result_address;
    logic        reused;
    logic        table_full;
    logic [31:0] pool_end;

    modport source (
        output valid, result_address, reused, table_full, pool_end,
        input  ready
    );
    modport sink (
        input  valid, result_address, reused, table_full, pool_end,
        output ready
    );
endinterface

interface lpdt_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] pass_number;

    modport source (
        output valid, pass_number,
        input  ready
    );
    modport sink (
        input  valid, pass_number,
        output ready
    );
endinterface

>>> rtl/lpdt_cell.sv
// One entry cell of the literal pool table: holds a stored literal, compares
// it against the broadcast query and passes the running search result on.
// Depends on lpdt_pkg.
`timescale 1ns / 1ps

module lpdt_cell (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lpdt_pkg::query_t      query,
    input  logic                  in_use,
    input  logic                  wr_en,
    input  lpdt_pkg::cell_ctl_t   ctl,
    input  lpdt_pkg::link_t       link_in,
    output lpdt_pkg::link_t       link_out
);

    logic [2:0]                       kind_reg;
    logic [31:0]                      first_reg;
    logic [31:0]                      second_reg;
    logic [lpdt_pkg::SYMBOL_BITS-1:0] symbol_reg;
    logic [31:0]                      address_reg;
    logic                             placed_reg;
    logic                             hit_reg;
    logic [31:0]                      link_addr_reg;

    logic [31:0] delta;
    logic [31:0] mag;
    logic        reach;
    logic        match;

    // Distance from the instruction's pc plus 8, folded to a magnitude.
    always_comb
    begin
        delta = address_reg - query.pc_ahead;
        mag   = delta[31] ? (32'd0 - delta) : delta;
        reach = query.is_float ? (mag < lpdt_pkg::RANGE_FP) : (mag < lpdt_pkg::RANGE_INT);
        match = in_use && (kind_reg == query.kind) && (first_reg == query.first_word)
                && (second_reg == query.second_word) && (symbol_reg == query.symbol)
                && (!placed_reg || reach);
    end

    // Stored entry: written on insert, moved to the pool base on close.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            kind_reg    <= query.kind;
            first_reg   <= query.first_word;
            second_reg  <= query.second_word;
            symbol_reg  <= query.symbol;
            address_reg <= ctl.wr_address;
            placed_reg  <= ctl.wr_placed;
        end
        else if (ctl.place_en && in_use && !placed_reg)
        begin
            address_reg <= ctl.place_base;
            placed_reg  <= 1'b1;
        end
    end

    // Search link: the earliest match along the row wins.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= link_in.hit | match;
        end
    end

    always_ff @(posedge clk)
    begin
        link_addr_reg <= link_in.hit ? link_in.address : address_reg;
    end

    assign link_out.hit     = hit_reg;
    assign link_out.address = link_addr_reg;

endmodule

>>> rtl/literal_pool_dedup_table.sv
// Top level of the literal pool table: request sequencer, pool pointers and
// the row of entry cells. Depends on lpdt_pkg, lpdt_if and lpdt_cell.
//
//   channel  role    beat carries
//   req      sink    mode, known_status, value_low/high, symbol_id, pc, pool start
//   rsp      source  result_address, reused, table_full, pool_end
//   cfg      sink    pass_number
//
// An add with a known value runs a search first: the search result
// ripples through the row of TABLE_DEPTH cells, one cell a cycle.
// Start, close, unresolved reserve and unused codes skip the search.
// A request beat is taken only while no request is in work; a finished
// response waits in the output register while the next request is accepted.
// Reset clears the pointers, the entry count and the control state; sets pass 1.
`timescale 1ns / 1ps

module literal_pool_dedup_table (
    input  logic       clk,
    input  logic       rst_n,
    lpdt_req_if.sink   req,
    lpdt_rsp_if.source rsp,
    lpdt_cfg_if.sink   cfg
);

    localparam int D = lpdt_pkg::TABLE_DEPTH;

    lpdt_pkg::state_t state_reg, state_next;

    logic [lpdt_pkg::IDX_W-1:0] cnt_reg;
    logic [lpdt_pkg::CNT_W-1:0] count_reg, count_next;
    logic [31:0]                nla_reg, nla_next;
    logic [31:0]                pb_reg, pb_next;
    logic [1:0]                 pass_reg;

    // Captured request.
    logic [2:0]                       q_mode_reg;
    logic                             q_known_reg;
    logic [31:0]                      q_lo_reg;
    logic [31:0]                      q_hi_reg;
    logic [lpdt_pkg::SYMBOL_BITS-1:0] q_sym_reg;
    logic [31:0]                      q_pc_reg;
    logic [31:0]                      q_pc8_reg;
    logic [31:0]                      q_pstart_reg;

    // Response register.
    logic        rv_reg;
    logic [31:0] r_addr_reg, r_addr_next;
    logic        r_reused_reg, r_reused_next;
    logic        r_full_reg, r_full_next;
    logic [31:0] r_end_reg, r_end_next;

    logic req_fire;
    logic needs_search;
    logic commit;
    logic do_insert;
    logic table_has_room;

    lpdt_pkg::query_t    query;
    lpdt_pkg::cell_ctl_t ctl;
    lpdt_pkg::link_t     link [D+1];

    // Handshakes.
    assign req_fire  = req.valid && req.ready;
    assign cfg.ready = 1'b1;
    assign needs_search = (req.mode <= lpdt_pkg::MODE_DOUBLE)
        && !((req.mode <= lpdt_pkg::MODE_ADDR) && !req.known_status);

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lpdt_pkg::ST_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = needs_search ? lpdt_pkg::ST_SEARCH : lpdt_pkg::ST_FINISH;
                end
            end
            lpdt_pkg::ST_SEARCH:
            begin
                if (cnt_reg == lpdt_pkg::IDX_W'(D - 1))
                begin
                    state_next = lpdt_pkg::ST_FINISH;
                end
            end
            lpdt_pkg::ST_FINISH:
            begin
                if (!rv_reg || rsp.ready)
                begin
                    state_next = lpdt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lpdt_pkg::ST_IDLE;
            end
        endcase
    end

    // Output decode of the sequencer.
    always_comb
    begin
        req.ready = 1'b0;
        commit    = 1'b0;
        unique case (state_reg)
            lpdt_pkg::ST_IDLE:   req.ready = 1'b1;
            lpdt_pkg::ST_SEARCH: commit    = 1'b0;
            lpdt_pkg::ST_FINISH: commit    = !rv_reg || rsp.ready;
            default:             commit    = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lpdt_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= (state_reg == lpdt_pkg::ST_SEARCH) ? cnt_reg + 1'b1 : '0;
        end
    end

    // Request capture.
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            q_mode_reg   <= req.mode;
            q_known_reg  <= req.known_status;
            q_lo_reg     <= req.value_low;
            q_hi_reg     <= req.value_high;
            q_sym_reg    <= req.symbol_id;
            q_pc_reg     <= req.program_counter;
            q_pc8_reg    <= req.program_counter + lpdt_pkg::PC_AHEAD;
            q_pstart_reg <= req.pool_start_address;
        end
    end

    // Query as stored and compared by the cells.
    always_comb
    begin
        query.kind        = q_mode_reg;
        query.first_word  = q_lo_reg;
        query.second_word = (q_mode_reg == lpdt_pkg::MODE_DOUBLE) ? q_hi_reg : 32'd0;
        query.symbol      = (q_mode_reg == lpdt_pkg::MODE_EXTERN) ? q_sym_reg : '0;
        query.pc_ahead    = q_pc8_reg;
        query.is_float    = (q_mode_reg >= lpdt_pkg::MODE_SINGLE);
    end

    assign table_has_room = (count_reg != lpdt_pkg::CNT_W'(D));

    // Request completion: pointer updates, entry writes and the response.
    always_comb
    begin
        logic [31:0] step;
        logic [31:0] base;
        step = (q_mode_reg == lpdt_pkg::MODE_DOUBLE) ? lpdt_pkg::STEP_DOUBLE
                                                     : lpdt_pkg::STEP_WORD;
        base = (q_pc_reg + 32'd3) & ~32'd3;

        count_next     = count_reg;
        nla_next       = nla_reg;
        pb_next        = pb_reg;
        do_insert      = 1'b0;
        ctl.wr_placed  = (pass_reg == lpdt_pkg::PASS_TWO);
        ctl.wr_address = nla_reg;
        ctl.place_en   = 1'b0;
        ctl.place_base = base;
        r_addr_next    = 32'd0;
        r_reused_next  = 1'b0;
        r_full_next    = 1'b0;
        r_end_next     = 32'd0;

        if (q_mode_reg <= lpdt_pkg::MODE_DOUBLE)
        begin
            if ((q_mode_reg <= lpdt_pkg::MODE_ADDR) && !q_known_reg)
            begin
                // Unresolved value: reserve a word only.
                r_addr_next = nla_reg;
                nla_next    = nla_reg + lpdt_pkg::STEP_WORD;
                pb_next     = pb_reg + lpdt_pkg::STEP_WORD;
            end
            else if (link[D].hit)
            begin
                r_addr_next   = link[D].address;
                r_reused_next = 1'b1;
            end
            else
            begin
                r_addr_next = nla_reg;
                if (table_has_room)
                begin
                    do_insert  = 1'b1;
                    count_next = count_reg + 1'b1;
                end
                else
                begin
                    r_full_next = 1'b1;
                end
                if (pass_reg == lpdt_pkg::PASS_ONE)
                begin
                    pb_next = pb_reg + step;
                end
                nla_next = nla_reg + step;
            end
        end
        else if (q_mode_reg == lpdt_pkg::MODE_START)
        begin
            count_next  = '0;
            r_addr_next = nla_reg;
            if (pass_reg == lpdt_pkg::PASS_ONE)
            begin
                nla_next    = 32'd0;
                pb_next     = 32'd0;
                r_addr_next = 32'd0;
            end
            else if (pass_reg == lpdt_pkg::PASS_TWO)
            begin
                nla_next    = q_pstart_reg;
                r_addr_next = q_pstart_reg;
            end
        end
        else if (q_mode_reg == lpdt_pkg::MODE_CLOSE)
        begin
            if (pass_reg == lpdt_pkg::PASS_ONE)
            begin
                r_addr_next  = base;
                r_end_next   = base + pb_reg;
                ctl.place_en = (pb_reg != 32'd0);
            end
            else
            begin
                if (pb_reg != 32'd0)
                begin
                    r_addr_next = base;
                    r_end_next  = base + pb_reg;
                end
                else
                begin
                    r_addr_next = q_pc_reg;
                    r_end_next  = q_pc_reg;
                end
                if (pass_reg == lpdt_pkg::PASS_TWO)
                begin
                    nla_next = q_pstart_reg;
                end
            end
        end
        ctl.place_en = ctl.place_en && commit;
    end

    // Pool pointers, entry count and pass register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            nla_reg   <= 32'd0;
            pb_reg    <= 32'd0;
            pass_reg  <= lpdt_pkg::PASS_ONE;
        end
        else
        begin
            if (commit)
            begin
                count_reg <= count_next;
                nla_reg   <= nla_next;
                pb_reg    <= pb_next;
            end
            if (cfg.valid && cfg.ready)
            begin
                pass_reg <= cfg.pass_number;
            end
        end
    end

    // Response register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rv_reg <= 1'b0;
        end
        else if (commit)
        begin
            rv_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rv_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            r_addr_reg   <= r_addr_next;
            r_reused_reg <= r_reused_next;
            r_full_reg   <= r_full_next;
            r_end_reg    <= r_end_next;
        end
    end

    assign rsp.valid          = rv_reg;
    assign rsp.result_address = r_addr_reg;
    assign rsp.reused         = r_reused_reg;
    assign rsp.table_full     = r_full_reg;
    assign rsp.pool_end       = r_end_reg;

    // Row of entry cells.
    assign link[0] = '0;

    for (genvar i = 0; i < D; i++)
    begin : g_cell
        logic in_use;
        logic wr_en;
        assign in_use = (count_reg > lpdt_pkg::CNT_W'(i));
        assign wr_en  = commit && do_insert
                        && (count_reg[lpdt_pkg::IDX_W-1:0] == lpdt_pkg::IDX_W'(i));

        lpdt_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .query    (query),
            .in_use   (in_use),
            .wr_en    (wr_en),
            .ctl      (ctl),
            .link_in  (link[i]),
            .link_out (link[i+1])
        );
    end

endmodule

>>> rtl/lpdt_checker.sv
// Port-level checks for the literal pool table, bound to the top level.
// Depends on assert_macros.svh and the top level's channel ports.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lpdt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [31:0] rsp_result_address,
    input logic        rsp_reused,
    input logic        rsp_table_full,
    input logic [31:0] rsp_pool_end
);

    // A stalled response beat keeps its address.
    `LPDT_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_result_address), "response changed while stalled")

    // Only one request is in work at a time.
    `LPDT_ASSERT_NEXT(a_one_in_work, clk, rst_n, req_valid && req_ready, !req_ready, "request taken while another is in work")

    // A reused literal never reports a full table.
    `LPDT_ASSERT_SAME(a_reuse_not_full, clk, rst_n, rsp_valid && rsp_reused, !rsp_table_full, "reused and full together")

    // Pool end is reported by close only, which never reuses.
    `LPDT_ASSERT_SAME(a_reuse_no_end, clk, rst_n, rsp_valid && rsp_reused, rsp_pool_end == 32'd0, "pool end on a reused literal")

endmodule

bind literal_pool_dedup_table lpdt_checker u_lpdt_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .req_valid          (req.valid),
    .req_ready          (req.ready),
    .rsp_valid          (rsp.valid),
    .rsp_ready          (rsp.ready),
    .rsp_result_address (rsp.result_address),
    .rsp_reused         (rsp.reused),
    .rsp_table_full     (rsp.table_full),
    .rsp_pool_end       (rsp.pool_end)
);
